// File: src/lpf_pkg.sv
`default_nettype none
package lpf_pkg;

  // Operand width and derived widths
  localparam int WIDTH   = 40;
  localparam int DIV_W   = (WIDTH + 1) / 2 + 1;        // odd trial divisor, up to sqrt + 2
  localparam int SQ_W    = 2 * DIV_W;                  // divisor squared
  localparam int CNT_W   = $clog2(WIDTH);              // divider bit counter
  localparam int TDATA_W = ((WIDTH + 7) / 8) * 8;      // stream data, whole bytes

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_STRIP,
    ST_SQUARE,
    ST_CHECK,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } lpf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // take a new number
    logic strip;     // divide out one factor 2
    logic square;    // register divisor squared
    logic div_init;  // start a long division of remainder by divisor
    logic div_step;  // one restoring division step
    logic apply;     // commit quotient or advance divisor
    logic finish;    // load the output register
  } lpf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad;       // number below two
    logic even;      // remainder is even
    logic sq_le_r;   // divisor squared does not exceed remainder
    logic div_last;  // final division step
    logic out_busy;  // output register holds an untaken result
  } lpf_sts_t;

endpackage
`default_nettype wire

// File: src/largest_prime_factor.sv
`default_nettype none
// Largest prime factor by trial division. Each transfer on the slave side
// carries one unsigned WIDTH-bit number; one transfer on the master side
// returns its largest prime factor, or 0 with tuser set when the number is
// below two. Factors of two are shifted out at one per cycle, then odd
// divisors 3, 5, 7, ... are tried while divisor squared does not exceed the
// remaining cofactor; each trial is a square, a compare, WIDTH steps of a
// one-bit restoring divider and a commit, all on the single divider, and a
// divisor that divides repeats on the reduced cofactor. The trials per number
// thus number about sqrt(n) / 2 plus the number of odd prime factors. Only one
// number is worked on at a time; the result sits in an output register, so
// the block returns to accept the next number while the result waits.
module largest_prime_factor (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [lpf_pkg::TDATA_W-1:0] s_tdata,   // [WIDTH-1:0] number
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [lpf_pkg::TDATA_W-1:0]      m_tdata,   // [WIDTH-1:0] largest_factor
  output logic                             m_tuser    // [0] invalid
);
  import lpf_pkg::*;

  lpf_cmd_t cmd;
  lpf_sts_t sts;

  // Sequence the trial division
  lpf_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Remainder, divisor, divider and output register
  lpf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .number   (s_tdata[WIDTH-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

// File: src/lpf_datapath.sv
`default_nettype none
module lpf_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lpf_pkg::lpf_cmd_t            cmd,
  output lpf_pkg::lpf_sts_t                 sts,
  input  wire logic [lpf_pkg::WIDTH-1:0]    number,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [lpf_pkg::TDATA_W-1:0]       m_tdata,
  output logic                              m_tuser
);
  import lpf_pkg::*;

  logic [WIDTH-1:0] remainder;
  logic [DIV_W-1:0] divisor;
  logic [WIDTH-1:0] best_factor;
  logic [SQ_W-1:0]  square;
  logic [DIV_W-1:0] part_rem;
  logic [WIDTH-1:0] quotient;
  logic [CNT_W-1:0] count;
  logic             bad;
  logic [WIDTH-1:0] out_factor;
  logic             out_invalid;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic [WIDTH-1:0] final_factor;

  assign trial = {part_rem, quotient[WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  // Leftover cofactor above one is prime
  assign final_factor = (remainder > WIDTH'(1) && remainder > best_factor) ?
                        remainder : best_factor;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remainder   <= number;
      divisor     <= DIV_W'(3);
      best_factor <= '0;
      bad         <= number < WIDTH'(2);
    end
    if (cmd.strip) begin
      remainder   <= remainder >> 1;
      best_factor <= WIDTH'(2);
    end
    if (cmd.square) begin
      square <= SQ_W'(divisor) * SQ_W'(divisor);
    end
    if (cmd.div_init) begin
      part_rem <= '0;
      quotient <= remainder;
      count    <= '0;
    end
    if (cmd.div_step) begin
      part_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quotient <= {quotient[WIDTH-2:0], fits};
      count    <= count + CNT_W'(1);
    end
    if (cmd.apply) begin
      if (part_rem == '0) begin
        remainder   <= quotient;
        best_factor <= WIDTH'(divisor);
      end else begin
        divisor <= divisor + DIV_W'(2);
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_factor  <= bad ? '0 : final_factor;
      out_invalid <= bad;
    end
  end

  assign m_tdata = TDATA_W'(out_factor);
  assign m_tuser = out_invalid;

  assign sts.bad      = bad;
  assign sts.even     = ~remainder[0];
  assign sts.sq_le_r  = square <= SQ_W'(remainder);
  assign sts.div_last = count == CNT_W'(WIDTH - 1);
  assign sts.out_busy = m_tvalid & ~m_tready;

endmodule
`default_nettype wire

// File: src/lpf_controller.sv
`default_nettype none
module lpf_controller (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire lpf_pkg::lpf_sts_t  sts,
  output lpf_pkg::lpf_cmd_t       cmd
);
  import lpf_pkg::*;

  lpf_state_t state;
  lpf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_CLASSIFY;
      ST_CLASSIFY: state_next = sts.bad ? ST_DONE : ST_STRIP;
      ST_STRIP:    if (!sts.even) state_next = ST_SQUARE;
      ST_SQUARE:   state_next = ST_CHECK;
      ST_CHECK:    state_next = sts.sq_le_r ? ST_DIV : ST_DONE;
      ST_DIV:      if (sts.div_last) state_next = ST_APPLY;
      ST_APPLY:    state_next = ST_SQUARE;
      ST_DONE:     if (!sts.out_busy) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_STRIP:  cmd.strip    = sts.even;
      ST_SQUARE: cmd.square   = 1'b1;
      ST_CHECK:  cmd.div_init = sts.sq_le_r;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_APPLY:  cmd.apply    = 1'b1;
      ST_DONE:   cmd.finish   = ~sts.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: test/tb_largest_prime_factor.sv
module tb_largest_prime_factor;
  timeunit 1ns;
  timeprecision 1ps;

  import lpf_pkg::*;

  localparam logic [63:0] MAX_NUM     = (64'd1 << WIDTH) - 64'd1;
  localparam int          NO_CAP      = 32'h7fff_ffff;
  // Keep random numbers cheap: each trial step runs the whole divider in the block.
  localparam int          RANDOM_CAP  = 200;
  localparam int          RANDOM_NUMS = 84;
  localparam int          HOLD_AT     = 8;      // results seen before the long hold-off
  // Long enough for the next two numbers to finish, so the block stalls in front of
  // a full output register while the sender keeps offering.
  localparam int          HOLD_CYCLES = 12_000;
  localparam int          DRAIN_WAIT  = 200;
  localparam int          CYCLE_LIMIT = 4_000_000;

  typedef struct {
    logic [WIDTH-1:0] factor;
    logic             invalid;
  } factor_result_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata;   // [WIDTH-1:0] number
  logic                m_tvalid;
  logic                m_tready;
  logic [TDATA_W-1:0]  m_tdata;   // [WIDTH-1:0] largest_factor
  logic                m_tuser;   // [0] invalid

  int cycles;
  int small_primes[24] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                           43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

  largest_prime_factor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Strip factors of two, then try odd divisors while d*d <= cofactor. A cofactor
  // left above one is prime. Steps counts odd-divisor iterations; stop at cap.
  function automatic void factor_number(input logic [WIDTH-1:0] n, input int cap,
                                        output logic [WIDTH-1:0] factor,
                                        output logic invalid, output int steps);
    logic [63:0] cofactor;
    logic [63:0] d;
    logic [63:0] best;
    steps = 0;
    if (n < 2) begin
      factor  = '0;
      invalid = 1'b1;
      return;
    end
    cofactor = 64'(n);
    best     = 64'd0;
    while (cofactor[0] == 1'b0) begin
      cofactor = cofactor >> 1;
      best     = 64'd2;
    end
    d = 64'd3;
    while (d <= cofactor / d && steps < cap) begin
      steps++;
      if (cofactor % d == 64'd0) begin
        cofactor = cofactor / d;
        best     = d;
      end else begin
        d = d + 64'd2;
      end
    end
    if (cofactor > 64'd1 && cofactor > best) best = cofactor;
    factor  = best[WIDTH-1:0];
    invalid = 1'b0;
  endfunction

  class factor_scoreboard;
    factor_result_t pending_q[$];
    int errors;
    int checked;
    int numbers;
    int below_two;
    int deepest;

    function void note_number(logic [WIDTH-1:0] n);
      factor_result_t want;
      int steps;
      factor_number(n, NO_CAP, want.factor, want.invalid, steps);
      numbers++;
      if (want.invalid) below_two++;
      if (steps > deepest) deepest = steps;
      pending_q.push_back(want);
    endfunction

    function void check_result(logic [WIDTH-1:0] factor, logic invalid);
      factor_result_t want;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result factor=%0d invalid=%0b", $time, factor, invalid);
        return;
      end
      want = pending_q.pop_front();
      if (factor !== want.factor) begin
        errors++;
        $display("%0t: largest_factor mismatch: expected %0d, got %0d",
                 $time, want.factor, factor);
      end
      if (invalid !== want.invalid) begin
        errors++;
        $display("%0t: invalid mismatch: expected %0b, got %0b",
                 $time, want.invalid, invalid);
      end
    endfunction
  endclass

  factor_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending",
               cycles, sb.pending_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bit take_gap(bit quiet);
    return !quiet && ($urandom_range(0, 99) < 28);
  endfunction

  // Draw a random number whose trial search stays short. Smooth products and
  // shifted odd values reach the high bits; shifted random words cover the rest.
  function automatic logic [WIDTH-1:0] draw_number();
    logic [63:0]      v;
    logic [WIDTH-1:0] factor;
    logic             invalid;
    int               steps;
    int               shape;
    int               k;
    do begin
      shape = $urandom_range(0, 9);
      if (shape <= 3) begin
        v = 64'd1;
        repeat ($urandom_range(1, 20)) begin
          k = small_primes[$urandom_range(0, 23)];
          if (v * k <= MAX_NUM) v = v * k;
        end
      end else if (shape <= 6) begin
        v = {$urandom, $urandom} & MAX_NUM;
        v = v >> $urandom_range(8, WIDTH - 1);
      end else if (shape <= 8) begin
        v = 64'($urandom_range(1, 65535)) | 64'd1;
      end else begin
        v = 64'($urandom_range(0, 3));
      end
      // Shift odd bases up by a random amount that still fits.
      if (shape <= 3 || (shape >= 7 && shape <= 8)) begin
        k = $urandom_range(0, WIDTH - 1);
        while (k > 0 && (v << k) > MAX_NUM) k--;
        v = v << k;
      end
      factor_number(v[WIDTH-1:0], RANDOM_CAP, factor, invalid, steps);
    end while (steps >= RANDOM_CAP);
    return v[WIDTH-1:0];
  endfunction

  // Offer one number and hold it until the block takes the transfer.
  task automatic send_number(input logic [WIDTH-1:0] n, input bit quiet);
    while (take_gap(quiet)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'(n);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_number(n);
  endtask

  // Receiver: random back-pressure, one long hold-off, a stretch with none.
  initial begin
    int  held_for;
    bit  held;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sb.checked == HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        for (held_for = 0; held_for < HOLD_CYCLES; held_for++) @(posedge clk);
      end else begin
        m_tready <= !take_gap(sb.checked >= 50 && sb.checked < 75);
        @(posedge clk);
        if (m_tvalid && m_tready) sb.check_result(m_tdata[WIDTH-1:0], m_tuser);
      end
    end
  end

  // Sender and end of run.
  initial begin
    logic [WIDTH-1:0] directed[$];
    int               i;
    directed = '{
      40'd0, 40'd1, 40'd2, 40'd3, 40'd4, 40'd6, 40'd12, 40'd97, 40'd2401,
      40'(MAX_NUM),           // all ones: 3*5^2*11*17*31*41*61681
      40'd1 << (WIDTH - 1),   // top bit only
      40'd847288609443,       // 3^25
      40'd762939453125,       // 5^17
      40'd259081,             // 509^2: the prime repeats
      40'd1000003,            // prime input
      40'd1048579145728       // 2^20 * 1000003
    };
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[j]) send_number(directed[j], 1'b0);
    for (i = 0; i < RANDOM_NUMS; i++) send_number(draw_number(), i >= 40 && i < 70);
    s_tvalid <= 1'b0;

    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Factored %0d numbers (%0d below two), longest odd-divisor search %0d steps.",
             sb.numbers, sb.below_two, sb.deepest);
    $display("Output held off for %0d cycles once while numbers kept arriving.",
             HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               sb.errors, sb.pending_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lpf_pkg.sv
src/lpf_datapath.sv
src/lpf_controller.sv
src/largest_prime_factor.sv
test/tb_largest_prime_factor.sv
